/* hw/rtl/cse_pkg.sv */
package cse_pkg;

  localparam int TIME_W = 32;
  localparam int EDGE_W = 8;
  localparam int SPEED_W = 30;
  localparam int ACCEL_W = 32;
  localparam int USEC_W = 20;

  // shared divider sizes: numerator covers |dspeed| * 1e6, divisor covers period * 16
  localparam int DIV_NW = SPEED_W + USEC_W;
  localparam int DIV_DW = TIME_W + 4;
  localparam int DIV_CW = 6;

  localparam logic [SPEED_W-1:0] SPEED_NUM = 30'd960000000;
  localparam logic [USEC_W-1:0] USEC_PER_S = 20'd1000000;
  localparam logic [EDGE_W-1:0] EDGE_MAX = {EDGE_W{1'b1}};

  localparam logic CMD_EDGE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic [1:0] HEALTH_VALID = 2'd0;
  localparam logic [1:0] HEALTH_STABILIZING = 2'd1;
  localparam logic [1:0] HEALTH_FAILED = 2'd2;
  localparam logic [1:0] HEALTH_STALE = 2'd3;

  localparam logic [1:0] QUALITY_GOOD = 2'd0;
  localparam logic [1:0] QUALITY_SUSPECT = 2'd1;
  localparam logic [1:0] QUALITY_BAD = 2'd2;

  localparam logic [1:0] FAULT_NONE = 2'b00;
  localparam logic [1:0] FAULT_PLAUSIBILITY = 2'b01;
  localparam logic [1:0] FAULT_STALE = 2'b10;

  localparam logic [1:0] REG_MIN_RPM = 2'd0;
  localparam logic [1:0] REG_MAX_RPM = 2'd1;
  localparam logic [1:0] REG_SYNC_EDGES = 2'd2;
  localparam logic [1:0] REG_STALE_TIMEOUT = 2'd3;

  typedef struct packed {
    logic command;
    logic [TIME_W-1:0] time_us;
  } in_item_t;

  typedef struct packed {
    logic [1:0] health;
    logic [1:0] quality;
    logic [1:0] fault_mask;
    logic [TIME_W-1:0] edge_period;
    logic [SPEED_W-1:0] speed_x16;
    logic signed [ACCEL_W-1:0] accel_rpm_s;
    logic [31:0] revolution_count;
    logic synchronized;
    logic control_ok;
    logic [TIME_W-1:0] sample_time;
    logic [TIME_W-1:0] edge_time;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SPEED,
    ST_CHECK,
    ST_MUL,
    ST_START_ACCEL,
    ST_ACCEL,
    ST_COMMIT,
    ST_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic div_start;
    logic div_accel;
    logic latch_speed;
    logic latch_accel;
    logic check;
    logic mul;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic have_edge;
    logic div_done;
    logic skip_accel;
  } dp_status_t;

endpackage

/* hw/rtl/cse_div.sv */
module cse_div (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [cse_pkg::DIV_NW-1:0] num,
  input  logic [cse_pkg::DIV_DW-1:0] den,
  output logic done,
  output logic [cse_pkg::DIV_NW-1:0] quo
);

  logic [cse_pkg::DIV_DW-1:0] rem;
  logic [cse_pkg::DIV_DW-1:0] divisor;
  logic [cse_pkg::DIV_CW-1:0] cnt;
  logic busy;
  logic [cse_pkg::DIV_DW:0] rem_sh;
  logic [cse_pkg::DIV_DW:0] rem_sub;
  logic fits;

  // one restoring step per cycle
  assign rem_sh = {rem, quo[cse_pkg::DIV_NW-1]};
  assign rem_sub = rem_sh - {1'b0, divisor};
  assign fits = rem_sh >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == cse_pkg::DIV_CW'(cse_pkg::DIV_NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // operand and partial remainder registers
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= num;
      divisor <= den;
    end else if (busy) begin
      rem <= fits ? rem_sub[cse_pkg::DIV_DW-1:0] : rem_sh[cse_pkg::DIV_DW-1:0];
      quo <= {quo[cse_pkg::DIV_NW-2:0], fits};
    end
  end

endmodule

/* hw/rtl/cse_ctrl.sv */
module cse_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  cse_pkg::dp_status_t status,
  output cse_pkg::ctrl_cmd_t cmd
);

  cse_pkg::ctrl_state_t state;
  cse_pkg::ctrl_state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cse_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd = '0;
    in_stall = 1'b1;
    out_valid = 1'b0;
    unique case (state)
      cse_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = cse_pkg::ST_DECIDE;
        end
      end
      cse_pkg::ST_DECIDE: begin
        if (status.is_tick || !status.have_edge) begin
          state_next = cse_pkg::ST_COMMIT;
        end else begin
          cmd.div_start = 1'b1;
          state_next = cse_pkg::ST_SPEED;
        end
      end
      cse_pkg::ST_SPEED: begin
        if (status.div_done) begin
          cmd.latch_speed = 1'b1;
          state_next = cse_pkg::ST_CHECK;
        end
      end
      cse_pkg::ST_CHECK: begin
        cmd.check = 1'b1;
        state_next = cse_pkg::ST_MUL;
      end
      cse_pkg::ST_MUL: begin
        cmd.mul = 1'b1;
        state_next = status.skip_accel ? cse_pkg::ST_COMMIT : cse_pkg::ST_START_ACCEL;
      end
      cse_pkg::ST_START_ACCEL: begin
        cmd.div_start = 1'b1;
        cmd.div_accel = 1'b1;
        state_next = cse_pkg::ST_ACCEL;
      end
      cse_pkg::ST_ACCEL: begin
        cmd.div_accel = 1'b1;
        if (status.div_done) begin
          cmd.latch_accel = 1'b1;
          state_next = cse_pkg::ST_COMMIT;
        end
      end
      cse_pkg::ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = cse_pkg::ST_OUT;
      end
      cse_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_next = cse_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = cse_pkg::ST_IDLE;
      end
    endcase
  end

  // no new transfer while a result is pending
  a_out_blocks_in: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken while result pending");

  // every commit presents a result next cycle
  a_commit_out: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("commit did not present a result");

  // divider never finishes right after a start
  a_div_latency: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |=> !status.div_done)
    else $error("divider done too early");

  // a divider start is only issued from idle-divider states
  a_start_state: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> (state == cse_pkg::ST_DECIDE || state == cse_pkg::ST_START_ACCEL))
    else $error("divider started from wrong state");

endmodule

/* hw/rtl/cse_dp.sv */
module cse_dp (
  input  logic clk,
  input  logic rst,
  input  cse_pkg::in_item_t in_data,
  input  logic cfg_write,
  input  logic [1:0] cfg_index,
  input  logic [31:0] cfg_data,
  input  cse_pkg::ctrl_cmd_t cmd,
  output cse_pkg::dp_status_t status,
  output cse_pkg::out_item_t held
);

  logic [15:0] min_rpm;
  logic [15:0] max_rpm;
  logic [cse_pkg::EDGE_W-1:0] sync_edges;
  logic [31:0] stale_timeout;

  logic have_edge;
  logic [cse_pkg::TIME_W-1:0] last_edge_time;
  logic [cse_pkg::EDGE_W-1:0] edge_count;
  logic [cse_pkg::SPEED_W-1:0] prev_speed;
  logic [31:0] revolutions;

  logic is_tick;
  logic [cse_pkg::TIME_W-1:0] t_r;
  logic [cse_pkg::TIME_W-1:0] period;
  logic [cse_pkg::SPEED_W-1:0] speed;
  logic reject;
  logic neg;
  logic [cse_pkg::SPEED_W-1:0] mag;
  logic [cse_pkg::DIV_NW-1:0] prod;
  logic signed [cse_pkg::ACCEL_W-1:0] accel;

  logic [cse_pkg::TIME_W-1:0] elapsed;
  logic period_zero;
  logic div_done;
  logic [cse_pkg::DIV_NW-1:0] quo;
  logic [cse_pkg::DIV_NW-1:0] div_num;
  logic [cse_pkg::DIV_DW-1:0] div_den;
  logic [cse_pkg::SPEED_W-1:0] min_x16;
  logic [cse_pkg::SPEED_W-1:0] max_x16;
  logic [cse_pkg::EDGE_W-1:0] edge_inc;
  logic sync;
  logic stale;
  logic signed [cse_pkg::ACCEL_W-1:0] accel_sat;
  cse_pkg::out_item_t held_next;

  assign elapsed = t_r - last_edge_time;
  assign period_zero = (period == '0);
  assign min_x16 = {10'd0, min_rpm, 4'd0};
  assign max_x16 = {10'd0, max_rpm, 4'd0};

  // divider operands: speed pass or acceleration pass
  assign div_num = cmd.div_accel ? prod
                 : {{(cse_pkg::DIV_NW - cse_pkg::SPEED_W){1'b0}}, cse_pkg::SPEED_NUM};
  assign div_den = cmd.div_accel ? {period, 4'd0} : {4'd0, elapsed};

  cse_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (quo)
  );

  assign status.is_tick = is_tick;
  assign status.have_edge = have_edge;
  assign status.div_done = div_done;
  assign status.skip_accel = reject || period_zero;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      min_rpm <= 16'd0;
      max_rpm <= 16'hFFFF;
      sync_edges <= cse_pkg::EDGE_W'(2);
      stale_timeout <= 32'd1000000;
    end else if (cfg_write) begin
      unique case (cfg_index)
        cse_pkg::REG_MIN_RPM: min_rpm <= cfg_data[15:0];
        cse_pkg::REG_MAX_RPM: max_rpm <= cfg_data[15:0];
        cse_pkg::REG_SYNC_EDGES: sync_edges <= cfg_data[cse_pkg::EDGE_W-1:0];
        cse_pkg::REG_STALE_TIMEOUT: stale_timeout <= cfg_data;
        default: ;
      endcase
    end
  end

  // saturated signed acceleration from the quotient
  always_comb begin
    if (neg) begin
      if (quo > {{(cse_pkg::DIV_NW - 32){1'b0}}, 32'h8000_0000}) begin
        accel_sat = 32'sh8000_0000;
      end else begin
        accel_sat = -$signed(quo[31:0]);
      end
    end else begin
      if (quo > {{(cse_pkg::DIV_NW - 32){1'b0}}, 32'h7FFF_FFFF}) begin
        accel_sat = 32'sh7FFF_FFFF;
      end else begin
        accel_sat = $signed(quo[31:0]);
      end
    end
  end

  // working registers for one item
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      is_tick <= (in_data.command == cse_pkg::CMD_TICK);
      t_r <= in_data.time_us;
    end
    if (cmd.div_start && !cmd.div_accel) begin
      period <= elapsed;
    end
    if (cmd.latch_speed) begin
      speed <= period_zero ? '0 : quo[cse_pkg::SPEED_W-1:0];
    end
    if (cmd.check) begin
      reject <= (speed < min_x16) || (speed > max_x16);
      neg <= speed < prev_speed;
      mag <= (speed < prev_speed) ? prev_speed - speed : speed - prev_speed;
    end
    if (cmd.mul) begin
      prod <= mag * cse_pkg::USEC_PER_S;
      accel <= '0;
    end
    if (cmd.latch_accel) begin
      accel <= accel_sat;
    end
  end

  assign edge_inc = (edge_count < cse_pkg::EDGE_MAX) ? edge_count + 1'b1 : edge_count;
  assign sync = edge_inc >= sync_edges;
  assign stale = !have_edge || (elapsed > stale_timeout);

  // next held reading
  always_comb begin
    held_next = held;
    if (is_tick) begin
      if (stale) begin
        held_next.sample_time = t_r;
        held_next.synchronized = 1'b0;
        held_next.control_ok = 1'b0;
        held_next.health = cse_pkg::HEALTH_STALE;
        held_next.quality = cse_pkg::QUALITY_BAD;
        held_next.fault_mask = held.fault_mask | cse_pkg::FAULT_STALE;
      end
    end else begin
      held_next = '0;
      held_next.sample_time = t_r;
      held_next.edge_time = t_r;
      if (!have_edge) begin
        held_next.health = cse_pkg::HEALTH_STABILIZING;
        held_next.quality = cse_pkg::QUALITY_SUSPECT;
        held_next.fault_mask = cse_pkg::FAULT_NONE;
      end else if (reject) begin
        held_next.health = cse_pkg::HEALTH_FAILED;
        held_next.quality = cse_pkg::QUALITY_BAD;
        held_next.fault_mask = cse_pkg::FAULT_PLAUSIBILITY;
      end else begin
        held_next.health = sync ? cse_pkg::HEALTH_VALID : cse_pkg::HEALTH_STABILIZING;
        held_next.quality = cse_pkg::QUALITY_GOOD;
        held_next.fault_mask = cse_pkg::FAULT_NONE;
        held_next.edge_period = period;
        held_next.speed_x16 = speed;
        held_next.accel_rpm_s = period_zero ? '0 : accel;
        held_next.revolution_count = revolutions + 1'b1;
        held_next.synchronized = sync;
        held_next.control_ok = sync;
      end
    end
  end

  // tracking state and held reading
  always_ff @(posedge clk) begin
    if (rst) begin
      have_edge <= 1'b0;
      last_edge_time <= '0;
      edge_count <= '0;
      prev_speed <= '0;
      revolutions <= '0;
      held <= '0;
    end else if (cmd.commit) begin
      held <= held_next;
      if (is_tick) begin
        if (stale) begin
          have_edge <= 1'b0;
          edge_count <= '0;
          prev_speed <= '0;
        end
      end else if (!have_edge) begin
        have_edge <= 1'b1;
        last_edge_time <= t_r;
        edge_count <= cse_pkg::EDGE_W'(1);
      end else if (!reject) begin
        edge_count <= edge_inc;
        revolutions <= revolutions + 1'b1;
        last_edge_time <= t_r;
        prev_speed <= speed;
      end
    end
  end

  // a synchronized reading is never flagged stale or failed
  a_sync_health: assert property (@(posedge clk) disable iff (rst)
    held.synchronized |-> (held.health == cse_pkg::HEALTH_VALID))
    else $error("synchronized reading with bad health");

  // edge count only moves on commit
  a_count_commit: assert property (@(posedge clk) disable iff (rst)
    !$past(cmd.commit) && !$past(rst) |-> $stable(edge_count))
    else $error("edge count changed outside commit");

  // without an armed edge the count is clear
  a_count_armed: assert property (@(posedge clk) disable iff (rst)
    !have_edge |-> (edge_count == '0))
    else $error("edge count set while unarmed");

endmodule

/* hw/rtl/crank_speed_estimator.sv */
// Crank speed estimator.
// Input channel (in_valid, in_stall, in_data): one transfer carries either a
// crank edge capture time or a stale-check tick with the current time.
// Output channel (out_valid, out_stall, out_data): exactly one reading per
// input transfer, in order. Configuration port (cfg_write, cfg_index,
// cfg_data) sets min_rpm, max_rpm, sync_edges and stale_timeout; write it
// only while the block is idle.
// Items are handled one at a time. A tick or a first edge goes through the
// decide and commit states before its output transfer is offered. A later
// edge uses two passes of one shared bit-serial divider (50 steps each) for
// speed and acceleration, plus decide, check, multiply, start and commit
// states; a rejected or zero period edge skips the second pass. The block
// returns to idle after each output transfer before it takes the next item.
// in_stall stays high from a transfer until its result has been taken; a
// stalled receiver holds the result and the block waits.
// Reset (rst, synchronous) clears tracking state and the held reading and
// loads the default configuration.
module crank_speed_estimator (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  cse_pkg::in_item_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output cse_pkg::out_item_t out_data,
  input  logic cfg_write,
  input  logic [1:0] cfg_index,
  input  logic [31:0] cfg_data
);

  cse_pkg::ctrl_cmd_t cmd;
  cse_pkg::dp_status_t status;

  cse_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  cse_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .held      (out_data)
  );

endmodule
